FILE: sv/assert_macros.svh
// Assertion macros shared by the key matrix debounce RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, muted while rst_ni is low.
`define KMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kmd assertion failed");

// Same-cycle implication form.
`define KMD_ASSERT_IMPL(lbl, ante, cons) \
  `KMD_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication form.
`define KMD_ASSERT_NEXT(lbl, ante, cons) \
  `KMD_ASSERT(lbl, (ante) |=> (cons))

`endif

FILE: sv/kmd_pkg.sv
// Shared constants and types for the key matrix debounce block.
`timescale 1ns / 1ps

package kmd_pkg;

  // Default geometry of the matrix.
  localparam int ColumnsDef = 4;
  localparam int RowsDef    = 12;

  // Fixed field widths.
  localparam int ColW = 2;
  localparam int RowW = 12;
  localparam int CntW = 8;

  // Settle counter and debounce register value after reset.
  localparam logic [CntW-1:0] DebounceReset = 8'd10;

  // Per-row result handed from a lane to the merge stage.
  typedef struct packed {
    logic pressed;
    logic changed;
  } lane_res_t;

endpackage

FILE: sv/kmd_in_if.sv
// Request channel carrying one column sample.
`timescale 1ns / 1ps

interface kmd_in_if;
  logic                      valid;
  logic                      ready;
  logic [kmd_pkg::ColW-1:0]  column_index;
  logic [kmd_pkg::RowW-1:0]  row_levels;

  modport source (output valid, output column_index, output row_levels, input ready);
  modport sink   (input valid, input column_index, input row_levels, output ready);
endinterface

FILE: sv/kmd_out_if.sv
// Result channel carrying the debounced state of one column.
`timescale 1ns / 1ps

interface kmd_out_if;
  logic                      valid;
  logic                      ready;
  logic [kmd_pkg::ColW-1:0]  column_out;
  logic [kmd_pkg::RowW-1:0]  pressed_mask;
  logic [kmd_pkg::RowW-1:0]  changed_mask;

  modport source (output valid, output column_out, output pressed_mask,
                  output changed_mask, input ready);
  modport sink   (input valid, input column_out, input pressed_mask,
                  input changed_mask, output ready);
endinterface

FILE: sv/kmd_lane.sv
// One row lane: stable state and settle counter of this row for every column.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kmd_lane #(
  parameter int COLUMNS = kmd_pkg::ColumnsDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] idx_i,
  input  logic                                          raw_i,
  input  logic [kmd_pkg::CntW-1:0]                      dbc_i,
  output kmd_pkg::lane_res_t                            res_o
);

  logic                      stable_q [COLUMNS];
  logic [kmd_pkg::CntW-1:0]  cnt_q    [COLUMNS];

  logic                      cur;
  logic [kmd_pkg::CntW-1:0]  cnt;
  logic                      mismatch;
  logic                      flip;
  logic [kmd_pkg::CntW-1:0]  cnt_d;

  // Compare raw sample with stable state, count down or reload
  always_comb begin
    cur      = stable_q[idx_i];
    cnt      = cnt_q[idx_i];
    mismatch = raw_i != cur;
    flip     = mismatch && (cnt <= kmd_pkg::CntW'(1));
    cnt_d    = (mismatch && !flip) ? cnt - kmd_pkg::CntW'(1) : dbc_i;
    res_o.pressed = cur ^ flip;
    res_o.changed = flip;
  end

  // Per-column state of this row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        stable_q[c] <= 1'b0;
        cnt_q[c]    <= kmd_pkg::DebounceReset;
      end
    end else if (en_i) begin
      stable_q[idx_i] <= cur ^ flip;
      cnt_q[idx_i]    <= cnt_d;
    end
  end

  `KMD_ASSERT_NEXT(a_lane_countdown, en_i && mismatch && !flip, cnt_q[$past(idx_i)] == $past(cnt) - kmd_pkg::CntW'(1))
  `KMD_ASSERT_NEXT(a_lane_flip, en_i && flip, stable_q[$past(idx_i)] != $past(cur))

endmodule

FILE: sv/kmd_merge.sv
// Merge stage: gathers lane results into the masks and holds the result register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kmd_merge #(
  parameter int COLUMNS = kmd_pkg::ColumnsDef,
  parameter int LANES   = kmd_pkg::RowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      col_ok_i,
  input  logic [kmd_pkg::ColW-1:0]  col_i,
  input  kmd_pkg::lane_res_t        res_i [LANES],
  output logic                      ready_o,
  kmd_out_if.source                 out_o
);

  logic                      valid_q, valid_d;
  logic [kmd_pkg::ColW-1:0]  col_q;
  logic [kmd_pkg::RowW-1:0]  pressed_q, pressed_d;
  logic [kmd_pkg::RowW-1:0]  changed_q, changed_d;

  // Take a new request whenever the result register is empty or draining
  assign ready_o = !valid_q || out_o.ready;

  // Assemble masks; rows without a lane and bad columns read as zero
  always_comb begin
    pressed_d = '0;
    changed_d = '0;
    for (int l = 0; l < LANES; l++) begin
      pressed_d[l] = res_i[l].pressed & col_ok_i;
      changed_d[l] = res_i[l].changed & col_ok_i;
    end
    valid_d = accept_i || (valid_q && !out_o.ready);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      col_q     <= col_i;
      pressed_q <= pressed_d;
      changed_q <= changed_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.column_out   = col_q;
  assign out_o.pressed_mask = pressed_q;
  assign out_o.changed_mask = changed_q;

  `KMD_ASSERT_IMPL(a_bad_col_empty, valid_q && (32'(col_q) >= COLUMNS), (pressed_q == '0) && (changed_q == '0))
  `KMD_ASSERT_NEXT(a_result_loaded, accept_i, valid_q && (col_q == $past(col_i)))

endmodule

FILE: sv/key_matrix_debounce_top.sv
// Top level of the key matrix debounce block.
// Latency: a result is registered at the edge that accepts its sample, valid the next cycle.
// Throughput: one column sample per cycle while each result is taken; all row lanes update their counters in parallel.
// The input stays ready while a held result is being taken in the same cycle.
// Reset (async, active low): keys released, settle counters and debounce count at 10.
`timescale 1ns / 1ps

module key_matrix_debounce_top #(
  parameter int COLUMNS = kmd_pkg::ColumnsDef,
  parameter int ROWS    = kmd_pkg::RowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kmd_pkg::CntW-1:0]  cfg_wdata_i,
  kmd_in_if.sink                    in_i,
  kmd_out_if.source                 out_o
);

  // Rows above the input field width never change, so they get no lane
  localparam int LANES  = (ROWS < kmd_pkg::RowW) ? ROWS : kmd_pkg::RowW;
  localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [kmd_pkg::CntW-1:0]  dbc_q;
  logic                      ready;
  logic                      accept;
  logic                      col_ok;
  logic [CIDX_W-1:0]         col_idx;
  kmd_pkg::lane_res_t        res [LANES];

  // Debounce count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q <= kmd_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      dbc_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;
  assign col_ok     = 32'(in_i.column_index) < COLUMNS;
  assign col_idx    = CIDX_W'(in_i.column_index);

  // One lane per row; rows are active low on the pins
  for (genvar r = 0; r < LANES; r++) begin : g_lane
    kmd_lane #(
      .COLUMNS (COLUMNS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept && col_ok),
      .idx_i  (col_idx),
      .raw_i  (!in_i.row_levels[r]),
      .dbc_i  (dbc_q),
      .res_o  (res[r])
    );
  end

  kmd_merge #(
    .COLUMNS (COLUMNS),
    .LANES   (LANES)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .col_ok_i (col_ok),
    .col_i    (in_i.column_index),
    .res_i    (res),
    .ready_o  (ready),
    .out_o    (out_o)
  );

endmodule
